/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk with rst_n held low as the disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* src/y2r_pkg.sv */
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types and constants of the 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;  // holds MAX_SIDE itself
  localparam int CNT_W    = $clog2(MAX_SIDE);      // column / line counters
  localparam int CFG_W    = 13;                    // widest register
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_W = 16;
  localparam int COEF_W = 18;                      // signed, 16 fractional bits
  localparam int PROD_W = 8 + COEF_W;
  localparam int SUM_W  = 27;

  localparam logic signed [COEF_W-1:0] COEF_RV = COEF_W'(91881);
  localparam logic signed [COEF_W-1:0] COEF_GU = COEF_W'(22544);
  localparam logic signed [COEF_W-1:0] COEF_GV = COEF_W'(46793);
  localparam logic signed [COEF_W-1:0] COEF_BU = COEF_W'(116130);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // one macropixel with its chroma contributions already scaled
  typedef struct packed {
    logic [7:0]              luma_first;
    logic [7:0]              luma_second;
    logic signed [SUM_W-1:0] red_term;
    logic signed [SUM_W-1:0] green_term;   // subtracted from luma
    logic signed [SUM_W-1:0] blue_term;
  } mp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/y2r_front.sv */
// ----------------------------------------------------------------------------
// y2r_front
// Takes macropixel requests and scales the shared chroma pair into terms.
// ----------------------------------------------------------------------------
module y2r_front import y2r_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_luma_first,
  input  logic [7:0]  in_chroma_blue,
  input  logic [7:0]  in_luma_second,
  input  logic [7:0]  in_chroma_red,
  input  q_status_t   q_status,
  output logic        push,
  output mp_entry_t   push_data
);

  logic signed [7:0]        cb_s;
  logic signed [7:0]        cr_s;
  logic signed [PROD_W-1:0] rv_prod;
  logic signed [PROD_W-1:0] gu_prod;
  logic signed [PROD_W-1:0] gv_prod;
  logic signed [PROD_W-1:0] bu_prod;

  // x - 128 on an 8-bit code is a flip of the top bit
  assign cb_s = $signed(in_chroma_blue ^ 8'h80);
  assign cr_s = $signed(in_chroma_red ^ 8'h80);

  assign rv_prod = PROD_W'(cr_s) * PROD_W'(COEF_RV);
  assign gu_prod = PROD_W'(cb_s) * PROD_W'(COEF_GU);
  assign gv_prod = PROD_W'(cr_s) * PROD_W'(COEF_GV);
  assign bu_prod = PROD_W'(cb_s) * PROD_W'(COEF_BU);

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_data.luma_first  = in_luma_first;
    push_data.luma_second = in_luma_second;
    push_data.red_term    = SUM_W'(rv_prod);
    push_data.green_term  = SUM_W'(gu_prod) + SUM_W'(gv_prod);
    push_data.blue_term   = SUM_W'(bu_prod);
  end

endmodule

/* src/y2r_queue.sv */
// ----------------------------------------------------------------------------
// y2r_queue
// Short register FIFO between the front and back halves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module y2r_queue import y2r_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mp_entry_t  push_data,
  input  logic       pop,
  output mp_entry_t  pop_data,
  output q_status_t  q_status
);

  mp_entry_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r,  count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_status.full  = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_data       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_q_overflow, push && q_status.full, "push into full queue")
  `ASSERT_NEVER(a_q_underflow, pop && q_status.empty, "pop from empty queue")
  `ASSERT_CLK(a_q_fill, push && !pop |=> count_r == $past(count_r) + 1'b1, "fill count lost")

endmodule

/* src/y2r_back.sv */
// ----------------------------------------------------------------------------
// y2r_back
// Emits two RGB pixels per macropixel, with line and frame position flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module y2r_back import y2r_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  q_status_t            q_status,
  input  mp_entry_t            head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_second_of_pair,
  output logic                 out_end_of_line,
  output logic                 out_end_of_frame
);

  logic [SIDE_W-1:0] width_eff_r,  width_eff_nxt;
  logic [SIDE_W-1:0] height_eff_r, height_eff_nxt;
  logic [CNT_W-1:0]  column_r, column_nxt;
  logic [CNT_W-1:0]  line_r,   line_nxt;
  logic              phase_r,  phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        red_r, green_r, blue_r;
  logic              second_r, eol_r, eof_r;

  logic                    advance;
  logic                    produce;
  logic [7:0]              luma;
  logic signed [SUM_W-1:0] luma_fx;
  logic signed [SUM_W-1:0] red_sum, green_sum, blue_sum;
  logic                    eol, eof;

  // zero acts as one, anything past the largest side saturates
  function automatic logic [SIDE_W-1:0] side_eff(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return SIDE_W'(1);
    end else if (int'(raw) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return SIDE_W'(raw);
  endfunction

  // truncate toward zero then saturate to 0..255
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1] || s == '0) begin
      return 8'd0;
    end else if (|s[SUM_W-2:FRAC_W+8]) begin
      return 8'hFF;
    end
    return s[FRAC_W+7:FRAC_W];
  endfunction

  assign advance = !out_valid_r || !out_stall;
  assign produce = !q_status.empty && advance;
  assign pop     = produce && phase_r;

  assign luma    = phase_r ? head.luma_second : head.luma_first;
  assign luma_fx = $signed({{(SUM_W - 8 - FRAC_W){1'b0}}, luma, {FRAC_W{1'b0}}});

  assign red_sum   = luma_fx + head.red_term;
  assign green_sum = luma_fx - head.green_term;
  assign blue_sum  = luma_fx + head.blue_term;

  // >= keeps a counter left beyond a shrunk size from running away
  assign eol = ({1'b0, column_r} + 1'b1) >= width_eff_r;
  assign eof = eol && (({1'b0, line_r} + 1'b1) >= height_eff_r);

  always_comb begin
    width_eff_nxt  = width_eff_r;
    height_eff_nxt = height_eff_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_eff_nxt  = side_eff(cfg_wdata);
        REG_FRAME_HEIGHT: height_eff_nxt = side_eff(cfg_wdata);
        default: ;
      endcase
    end

    column_nxt    = column_r;
    line_nxt      = line_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (produce) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = !phase_r;
      if (eol) begin
        column_nxt = '0;
        line_nxt   = eof ? '0 : line_r + 1'b1;
      end else begin
        column_nxt = column_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_eff_r  <= side_eff(WIDTH_RESET);
      height_eff_r <= side_eff(HEIGHT_RESET);
      column_r     <= '0;
      line_r       <= '0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      width_eff_r  <= width_eff_nxt;
      height_eff_r <= height_eff_nxt;
      column_r     <= column_nxt;
      line_r       <= line_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      red_r    <= clamp8(red_sum);
      green_r  <= clamp8(green_sum);
      blue_r   <= clamp8(blue_sum);
      second_r <= phase_r;
      eol_r    <= eol;
      eof_r    <= eof;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_second_of_pair = second_r;
  assign out_end_of_line    = eol_r;
  assign out_end_of_frame   = eof_r;

  `ASSERT_CLK(a_eof_has_eol, out_valid_r && eof_r |-> eol_r, "end of frame without end of line")
  `ASSERT_CLK(a_phase_hold, !produce |=> phase_r == $past(phase_r), "pixel phase moved while idle")

endmodule

/* src/yuyv_to_rgb888_converter.sv */
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter
// Packed 4:2:2 (Y0 U Y1 V) to RGB888, BT.601 full range, with frame flags.
// ----------------------------------------------------------------------------
// Each macropixel request yields two RGB pixels, Y0 first, on the output
// channel; the pixel output register gives one pixel per cycle while the
// output is not stalled and the queue is not empty. Each request is stored
// in the queue, and its pixels are then converted into the pixel output
// register. A two-entry queue lets input requests keep arriving while the
// output is stalled. frame_width and frame_height set where end_of_line
// and end_of_frame fall; write them only while idle.
module yuyv_to_rgb888_converter import y2r_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_luma_first,
  input  logic [7:0]           in_chroma_blue,
  input  logic [7:0]           in_luma_second,
  input  logic [7:0]           in_chroma_red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_second_of_pair,
  output logic                 out_end_of_line,
  output logic                 out_end_of_frame
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  mp_entry_t push_data;
  mp_entry_t head;

  y2r_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_luma_first  (in_luma_first),
    .in_chroma_blue (in_chroma_blue),
    .in_luma_second (in_luma_second),
    .in_chroma_red  (in_chroma_red),
    .q_status       (q_status),
    .push           (push),
    .push_data      (push_data)
  );

  y2r_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .q_status  (q_status)
  );

  y2r_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .q_status           (q_status),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_second_of_pair (out_second_of_pair),
    .out_end_of_line    (out_end_of_line),
    .out_end_of_frame   (out_end_of_frame)
  );

endmodule
